>>> rtl/core/pced_pkg.sv
package pced_pkg;

  localparam int unsigned NumPorts = 3;
  localparam int unsigned PortBits = 8;
  localparam int unsigned BitIdxW  = 3;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Port codes
  localparam logic [1:0] PortB = 2'd0;
  localparam logic [1:0] PortC = 2'd1;
  localparam logic [1:0] PortD = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegMaskB = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaskC = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaskD = 2'd2;

  // Pin number offsets
  localparam logic [4:0] PinBaseB = 5'd8;
  localparam logic [4:0] PinBaseC = 5'd14;
  localparam logic [4:0] PinBaseD = 5'd0;
  localparam logic [BitIdxW-1:0] UnmappedBitC = 3'd7;

  typedef struct packed {
    logic [1:0]          port_select;
    logic [PortBits-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_port;
    logic [4:0] event_pin;
    logic       event_pin_valid;
    logic       event_last;
  } out_item_t;

  // Work handed from change detection to the event emitter
  typedef struct packed {
    logic [1:0]          port;
    logic [PortBits-1:0] changed;
  } work_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] pin;
  } pin_map_t;

  function automatic pin_map_t map_pin(logic [1:0] port, logic [BitIdxW-1:0] bit_idx);
    pin_map_t m;
    m.valid = 1'b1;
    m.pin   = PinBaseD + {2'b00, bit_idx};
    if (port == PortB) begin
      m.pin = PinBaseB + {2'b00, bit_idx};
    end else if (port == PortC) begin
      if (bit_idx == UnmappedBitC) begin
        m.valid = 1'b0;
        m.pin   = 5'd0;
      end else begin
        m.pin = PinBaseC + {2'b00, bit_idx};
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/core/pced_detect.sv
module pced_detect (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            accept_i,
  input  pced_pkg::in_item_t              item_i,
  input  logic                            cfg_we_i,
  input  logic [pced_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pced_pkg::CfgDataW-1:0]   cfg_data_i,
  output pced_pkg::work_t                 work_o
);
  import pced_pkg::*;

  logic [PortBits-1:0] mask_q [NumPorts];
  logic [PortBits-1:0] prev_q [NumPorts];
  logic [PortBits-1:0] mask_sel;
  logic [PortBits-1:0] prev_sel;
  logic                port_ok;

  assign port_ok = (item_i.port_select == PortB) || (item_i.port_select == PortC) ||
                   (item_i.port_select == PortD);

  always_comb begin
    mask_sel = '0;
    prev_sel = '0;
    unique case (item_i.port_select)
      PortB: begin
        mask_sel = mask_q[0];
        prev_sel = prev_q[0];
      end
      PortC: begin
        mask_sel = mask_q[1];
        prev_sel = prev_q[1];
      end
      PortD: begin
        mask_sel = mask_q[2];
        prev_sel = prev_q[2];
      end
      default: begin
        mask_sel = '0;
        prev_sel = '0;
      end
    endcase
  end

  assign work_o.port    = item_i.port_select;
  assign work_o.changed = port_ok ? ((item_i.pin_levels ^ prev_sel) & mask_sel) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPorts; i++) begin
        mask_q[i] <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          RegMaskB: mask_q[0] <= cfg_data_i;
          RegMaskC: mask_q[1] <= cfg_data_i;
          RegMaskD: mask_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept_i) begin
        unique case (item_i.port_select)
          PortB:   prev_q[0] <= item_i.pin_levels;
          PortC:   prev_q[1] <= item_i.pin_levels;
          PortD:   prev_q[2] <= item_i.pin_levels;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> rtl/core/pced_emit.sv
module pced_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  pced_pkg::work_t      work_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pced_pkg::out_item_t  out_item_o
);
  import pced_pkg::*;

  logic [PortBits-1:0] pending_q, pending_d;
  logic [1:0]          port_q, port_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  logic [PortBits-1:0] low_bit;
  logic [PortBits-1:0] remain;
  logic [BitIdxW-1:0]  low_idx;
  logic                take;
  logic                move;
  pin_map_t            map;

  assign low_bit = pending_q & (~pending_q + 1'b1);
  assign remain  = pending_q & ~low_bit;

  always_comb begin
    low_idx = '0;
    for (int i = PortBits - 1; i >= 0; i--) begin
      if (pending_q[i]) low_idx = BitIdxW'(i);
    end
  end

  assign map        = map_pin(port_q, low_idx);
  assign take       = !out_valid_q || !out_stall_i;
  assign move       = take && (pending_q != '0);
  assign can_load_o = (pending_q == '0) || (move && (remain == '0));

  always_comb begin
    pending_d   = pending_q;
    port_d      = port_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (move) pending_d = remain;
    if (load_i) begin
      pending_d = work_i.changed;
      port_d    = work_i.port;
    end
    if (take) out_valid_d = move;
    if (move) begin
      out_item_d.event_port      = port_q;
      out_item_d.event_pin       = map.pin;
      out_item_d.event_pin_valid = map.valid;
      out_item_d.event_last      = (remain == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    port_q     <= port_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/core/pin_change_event_detector.sv
// Latency: an item's first event passes through the pending register, then
// the event output register, where out_stall_i can hold it. Throughput: one
// event per cycle while out_stall_i is low; an item raises up to 8 events,
// one per changed masked bit, through the single event output register.
// Reset (rst_ni low, asynchronous): masks and previous samples clear to zero,
// no events pending, output valid low.
module pin_change_event_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // sample channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  pced_pkg::in_item_t              in_item_i,
  // event channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output pced_pkg::out_item_t             out_item_o,
  // mask register write port
  input  logic                            cfg_we_i,
  input  logic [pced_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pced_pkg::CfgDataW-1:0]   cfg_data_i
);
  import pced_pkg::*;

  work_t work;
  logic  can_load;
  logic  in_accept;

  // A new item enters when the emitter has nothing left after this cycle,
  // so the next item overlaps the last event of the previous one.
  assign in_stall_o = !can_load;
  assign in_accept  = in_valid_i && can_load;

  // Change detection: XOR against the port's previous sample, masked.
  // The previous sample is updated on every accepted item of a real port.
  pced_detect u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .item_i      (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .work_o      (work)
  );

  // Event emitter: pops the lowest pending bit each cycle that the output
  // register is free or not stalled, mapping it to a board pin number.
  pced_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .work_i      (work),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> verif/tb_pin_change_event_detector.sv
`timescale 1ns / 1ps

module tb_pin_change_event_detector;
  import pced_pkg::*;

  // Selector code with no port behind it, and the register index with no register.
  localparam logic [1:0]         PortNone  = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;

  localparam int unsigned NumPhases     = 10;
  localparam int unsigned ItemsPerPhase = 32;
  // The first event passes the pending and output registers; leave some margin.
  localparam int unsigned SettleCycles  = 4;

  // Each directed row is either a register write or a sample. A sample row is
  // checked with the predictor, or it carries the expected result typed in:
  // no event at all, or exactly one event.
  typedef enum logic [1:0] {
    RowWrite,
    RowCheckModel,
    RowCheckNone,
    RowCheckOne
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  sel;       // register index for writes, port for samples
    logic [7:0]  value;     // mask data or pin levels
    out_item_t   typed_ev;  // used by RowCheckOne only
  } script_row_t;

  localparam out_item_t NoEvent = '0;
  localparam int unsigned ScriptLen = 24;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  // Shadow state of the detector: masks and last sample per port.
  logic [7:0] port_mask   [NumPorts];
  logic [7:0] last_levels [NumPorts];

  out_item_t   pending_events[$];
  script_row_t script [ScriptLen];

  int unsigned mismatches;
  int unsigned samples_sent;
  int unsigned dropped_sent;
  int unsigned events_seen;
  int unsigned mask_writes;
  bit          quiet_tail;

  pin_change_event_detector i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Board pin numbering: b -> 8+k, c -> 14+k (bit 7 unmapped), d -> k.
  function automatic out_item_t make_event(logic [1:0] port, int unsigned b,
                                           logic [7:0] changed);
    out_item_t ev;
    ev.event_port      = port;
    ev.event_pin_valid = 1'b1;
    case (port)
      PortB: ev.event_pin = PinBaseB + 5'(b);
      PortC: begin
        if (b == 7) begin
          ev.event_pin       = 5'd0;
          ev.event_pin_valid = 1'b0;
        end else begin
          ev.event_pin = PinBaseC + 5'(b);
        end
      end
      default: ev.event_pin = PinBaseD + 5'(b);
    endcase
    ev.event_last = ((changed >> (b + 1)) == 8'd0);
    return ev;
  endfunction

  // Called on acceptance of a sample: updates the shadow state and queues
  // the events it should raise. Typed rows replace the predicted events.
  task automatic record_sample(logic [1:0] port, logic [7:0] levels,
                               row_kind_e kind, out_item_t typed_ev);
    logic [7:0] changed;
    out_item_t  predicted[$];
    changed = '0;
    if (port != PortNone) begin
      changed = (levels ^ last_levels[port]) & port_mask[port];
      last_levels[port] = levels;
      for (int unsigned b = 0; b < PortBits; b++) begin
        if (changed[b]) predicted.push_back(make_event(port, b, changed));
      end
    end
    case (kind)
      RowCheckNone: ;
      RowCheckOne:  pending_events.push_back(typed_ev);
      default: foreach (predicted[i]) pending_events.push_back(predicted[i]);
    endcase
  endtask

  // Entered and left just after a falling edge.
  task automatic send_sample(logic [1:0] port, logic [7:0] levels,
                             row_kind_e kind, out_item_t typed_ev);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i = 1'b0;
      in_item_i  = in_item_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i            = 1'b1;
    in_item_i.port_select = port;
    in_item_i.pin_levels  = levels;
    do @(posedge clk_i); while (in_stall_o);
    record_sample(port, levels, kind, typed_ev);
    if (port == PortNone) dropped_sent++;
    else samples_sent++;
    @(negedge clk_i);
  endtask

  // Masks change only with nothing in flight, including samples that raise
  // no event and may still sit in the pipeline.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_mask(logic [CfgIdxW-1:0] index, logic [7:0] data);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_index_i = index;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (index < NumPorts) port_mask[index] = data;
    mask_writes++;
  endtask

  // Random sample: random levels, repeats, full flips or small changes against
  // the last level that raise events in ones and twos, with dropped selectors mixed in.
  task automatic send_random();
    logic [1:0] port;
    logic [7:0] levels;
    port = ($urandom_range(0, 15) == 0) ? PortNone : 2'($urandom_range(0, 2));
    if (port == PortNone) begin
      levels = 8'($urandom);
    end else begin
      case ($urandom_range(0, 5))
        0, 1: levels = 8'($urandom);
        2:    levels = last_levels[port];
        3:    levels = ~last_levels[port];
        default: levels = last_levels[port] ^ (8'd1 << $urandom_range(0, 7))
                          ^ (8'd1 << $urandom_range(0, 7));
      endcase
    end
    send_sample(port, levels, RowCheckModel, NoEvent);
  endtask

  function automatic logic [7:0] pick_mask();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Event checker: every accepted event against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      events_seen++;
      if (pending_events.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected event, expected none, actual port %0d pin %0d valid %0b last %0b",
                 $time, out_item_o.event_port, out_item_o.event_pin,
                 out_item_o.event_pin_valid, out_item_o.event_last);
      end else begin
        want = pending_events.pop_front();
        if (out_item_o.event_port !== want.event_port) begin
          mismatches++;
          $display("%0t: event_port expected %0d actual %0d",
                   $time, want.event_port, out_item_o.event_port);
        end
        if (out_item_o.event_pin !== want.event_pin) begin
          mismatches++;
          $display("%0t: event_pin expected %0d actual %0d",
                   $time, want.event_pin, out_item_o.event_pin);
        end
        if (out_item_o.event_pin_valid !== want.event_pin_valid) begin
          mismatches++;
          $display("%0t: event_pin_valid expected %0b actual %0b",
                   $time, want.event_pin_valid, out_item_o.event_pin_valid);
        end
        if (out_item_o.event_last !== want.event_last) begin
          mismatches++;
          $display("%0t: event_last expected %0b actual %0b",
                   $time, want.event_last, out_item_o.event_last);
        end
      end
    end
  end

  // Receiver backpressure: random stall bursts and calm stretches, none at
  // the tail.
  initial begin
    int unsigned burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_stall_i = 1'b0;
      if (!quiet_tail) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            burst = $urandom_range(1, 12);
            out_stall_i = 1'b1;
            repeat (burst) @(negedge clk_i);
            out_stall_i = 1'b0;
          end
          2: repeat ($urandom_range(20, 60)) @(negedge clk_i);
          default: ;
        endcase
      end
    end
  end

  // Main sequence.
  initial begin
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    quiet_tail  = 1'b0;
    mismatches  = 0;
    samples_sent = 0;
    dropped_sent = 0;
    events_seen  = 0;
    mask_writes  = 0;
    for (int i = 0; i < NumPorts; i++) begin
      port_mask[i]   = '0;
      last_levels[i] = '0;
    end

    script = '{
      // masks are zero out of reset: a full flip raises nothing
      '{RowCheckNone,  PortB,     8'hFF, NoEvent},
      '{RowWrite,      RegMaskB,  8'hFF, NoEvent},
      '{RowWrite,      RegMaskC,  8'hFF, NoEvent},
      '{RowWrite,      RegMaskD,  8'hFF, NoEvent},
      // write to the index with no register behind it
      '{RowWrite,      RegUnused, 8'h5A, NoEvent},
      // all eight bits of b change
      '{RowCheckModel, PortB,     8'h00, NoEvent},
      '{RowCheckNone,  PortB,     8'h00, NoEvent},
      // b bit 7 maps to pin 15
      '{RowCheckOne,   PortB,     8'h80, '{PortB, 5'd15, 1'b1, 1'b1}},
      '{RowCheckModel, PortB,     8'h40, NoEvent},
      // c bit 7 has no pin: pin field 0, marked invalid
      '{RowCheckOne,   PortC,     8'h80, '{PortC, 5'd0, 1'b0, 1'b1}},
      '{RowCheckModel, PortC,     8'h01, NoEvent},
      '{RowCheckModel, PortC,     8'hFF, NoEvent},
      '{RowCheckOne,   PortD,     8'h01, '{PortD, 5'd0, 1'b1, 1'b1}},
      '{RowCheckModel, PortD,     8'h80, NoEvent},
      '{RowCheckModel, PortD,     8'hFF, NoEvent},
      // unused selector: dropped, no state change
      '{RowCheckNone,  PortNone,  8'hAA, NoEvent},
      '{RowCheckNone,  PortD,     8'hFF, NoEvent},
      // masked-off change still updates the last sample
      '{RowWrite,      RegMaskC,  8'h00, NoEvent},
      '{RowCheckNone,  PortC,     8'h00, NoEvent},
      '{RowWrite,      RegMaskC,  8'h81, NoEvent},
      '{RowCheckModel, PortC,     8'h81, NoEvent},
      '{RowWrite,      RegMaskD,  8'h55, NoEvent},
      '{RowCheckModel, PortD,     8'h00, NoEvent},
      '{RowWrite,      RegMaskB,  8'h01, NoEvent}
    };

    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == RowWrite) begin
        write_mask(script[i].sel, script[i].value);
      end else begin
        send_sample(script[i].sel, script[i].value, script[i].kind, script[i].typed_ev);
      end
    end
    // last sample of b was 0x40 and only bit 0 is watched: pin 8
    send_sample(PortB, 8'h55, RowCheckOne, '{PortB, 5'd8, 1'b1, 1'b1});
    in_valid_i = 1'b0;

    // Random phases, each under its own mask setting. First all open, then all
    // closed, then mixed; the final phase runs without any idling.
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) begin
        write_mask(RegMaskB, 8'hFF);
        write_mask(RegMaskC, 8'hFF);
        write_mask(RegMaskD, 8'hFF);
      end else if (phase == 1) begin
        write_mask(RegMaskB, 8'h00);
        write_mask(RegMaskC, 8'h00);
        write_mask(RegMaskD, 8'h00);
      end else begin
        write_mask(RegMaskB, pick_mask());
        write_mask(RegMaskC, pick_mask());
        write_mask(RegMaskD, pick_mask());
        if ($urandom_range(0, 2) == 0) write_mask(RegUnused, 8'($urandom));
      end
      if (phase == NumPhases - 1) quiet_tail = 1'b1;
      for (int unsigned base = samples_sent; samples_sent - base < ItemsPerPhase; ) begin
        send_random();
      end
      in_valid_i = 1'b0;
    end

    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d port samples and %0d on the unused selector, %0d mask writes",
             samples_sent, dropped_sent, mask_writes);
    $display("Checked %0d pin change events, %0d mismatches", events_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d events still expected", pending_events.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pced_pkg.sv
rtl/core/pced_detect.sv
rtl/core/pced_emit.sv
rtl/core/pin_change_event_detector.sv
verif/tb_pin_change_event_detector.sv
